[design/positional_list_engine_assert.svh]
// Assertion macros shared by the list engine.
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("list engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

[design/ple_pkg.sv]
package ple_pkg;

    localparam int ACT_W    = 3;
    localparam int POS_W    = 6;
    localparam int HANDLE_W = 11;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 7;

    localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd1;
    localparam logic [ACT_W-1:0] ACT_INS_POS  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REM_HEAD = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REM_TAIL = 3'd4;
    localparam logic [ACT_W-1:0] ACT_REM_POS  = 3'd5;
    localparam logic [ACT_W-1:0] ACT_DUMP     = 3'd6;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd3;

    // What a cell loads on the next clock edge.
    typedef enum logic [1:0] {
        SEL_HOLD,
        SEL_LOAD,
        SEL_LEFT,
        SEL_RIGHT
    } t_cell_sel;

endpackage

[design/ple_in_if.sv]
interface ple_in_if;
    import ple_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [POS_W-1:0]    position;
    logic [HANDLE_W-1:0] record_handle;

    modport source (output valid, action, position, record_handle, input ready);
    modport sink   (input valid, action, position, record_handle, output ready);
endinterface

[design/ple_out_if.sv]
interface ple_out_if;
    import ple_pkg::*;

    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] out_handle;
    logic [STATUS_W-1:0] status;
    logic                handle_valid;
    logic                last;
    logic [LEN_W-1:0]    length_after;

    modport source (output valid, out_handle, status, handle_valid, last, length_after,
                    input ready);
    modport sink   (input valid, out_handle, status, handle_valid, last, length_after,
                    output ready);
endinterface

[design/ple_cell.sv]
module ple_cell #(
    parameter int WIDTH = 11
) (
    input  logic              i_clk,
    input  ple_pkg::t_cell_sel i_sel,
    input  logic [WIDTH-1:0]  i_left,
    input  logic [WIDTH-1:0]  i_right,
    input  logic [WIDTH-1:0]  i_new,
    output logic [WIDTH-1:0]  o_data
);
    import ple_pkg::*;

    logic [WIDTH-1:0] r_data;
    logic [WIDTH-1:0] n_data;

    always_comb begin
        case (i_sel)
            SEL_LOAD:  n_data = i_new;
            SEL_LEFT:  n_data = i_left;
            SEL_RIGHT: n_data = i_right;
            default:   n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[design/positional_list_engine.sv]
// Ordered list of up to CAPACITY handles, held in a row of cells where cell k
// is list position k. Inserts and removes shift the cells past the target
// position by one place at once, and the result of each insert or remove is
// registered; the next command is taken as soon as the output register is free.
// A dump rotates the occupied cells one place per cycle while the output
// register is free and emits the head each time, one result per entry (a single
// EMPTY result for an empty list), and leaves the list in its original order; no
// command is taken while a dump runs. Cells at or past the current length
// hold stale data that is never read. Action code 7 is taken and ignored.
`include "positional_list_engine_assert.svh"

module positional_list_engine #(
    parameter int CAPACITY    = 64,
    parameter int HANDLE_BITS = 11
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ple_in_if.sink    i_in,
    ple_out_if.source o_out
);
    import ple_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_ovalid, n_ovalid;
    logic [HANDLE_W-1:0] r_o_handle, n_o_handle;
    logic [STATUS_W-1:0] r_o_status, n_o_status;
    logic                r_o_hvalid, n_o_hvalid;
    logic                r_o_last, n_o_last;
    logic [LEN_W-1:0]    r_o_len, n_o_len;

    logic [HANDLE_BITS-1:0] w_cell [CAPACITY];
    t_cell_sel              w_sel  [CAPACITY];
    logic [HANDLE_BITS-1:0] w_new;

    logic                w_out_free;
    logic                w_acc;
    logic                w_is_ins, w_is_rem;
    logic [LEN_W-1:0]    w_count7;
    logic                w_full, w_empty;
    logic [LEN_W-1:0]    w_ins_tgt, w_rem_tgt;
    logic [STATUS_W-1:0] w_ins_st, w_rem_st;
    logic                w_do_ins, w_do_rem, w_do_rot;
    logic                w_dump_last;

    assign w_out_free  = !r_ovalid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_out_free;
    assign w_acc       = i_in.valid && i_in.ready;

    assign w_is_ins = i_in.action inside {ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS};
    assign w_is_rem = i_in.action inside {ACT_REM_HEAD, ACT_REM_TAIL, ACT_REM_POS};

    assign w_count7 = LEN_W'(r_count);
    assign w_full   = (w_count7 == LEN_W'(CAPACITY));
    assign w_empty  = (r_count == '0);

    always_comb begin
        case (i_in.action)
            ACT_INS_HEAD: w_ins_tgt = '0;
            ACT_INS_TAIL: w_ins_tgt = w_count7;
            default:      w_ins_tgt = LEN_W'(i_in.position);
        endcase
        case (i_in.action)
            ACT_REM_HEAD: w_rem_tgt = '0;
            ACT_REM_TAIL: w_rem_tgt = w_count7 - LEN_W'(1);
            default:      w_rem_tgt = LEN_W'(i_in.position);
        endcase
    end

    assign w_ins_st = w_full                  ? STAT_FULL  :
                      (w_ins_tgt > w_count7)  ? STAT_RANGE : STAT_OK;
    assign w_rem_st = w_empty                 ? STAT_EMPTY :
                      (w_rem_tgt >= w_count7) ? STAT_RANGE : STAT_OK;

    assign w_do_ins    = w_acc && w_is_ins && (w_ins_st == STAT_OK);
    assign w_do_rem    = w_acc && w_is_rem && (w_rem_st == STAT_OK);
    assign w_do_rot    = (r_state == S_DUMP) && w_out_free;
    assign w_dump_last = (r_idx == r_count - CNT_W'(1));

    // During a dump the head wraps around into the last occupied cell.
    assign w_new = w_do_rot ? w_cell[0] : HANDLE_BITS'(i_in.record_handle);

    always_comb begin
        for (int c = 0; c < CAPACITY; c++) begin
            w_sel[c] = SEL_HOLD;
            if (w_do_ins) begin
                if (LEN_W'(c) == w_ins_tgt) begin
                    w_sel[c] = SEL_LOAD;
                end else if (LEN_W'(c) > w_ins_tgt) begin
                    w_sel[c] = SEL_LEFT;
                end
            end else if (w_do_rem) begin
                if (LEN_W'(c) >= w_rem_tgt) begin
                    w_sel[c] = SEL_RIGHT;
                end
            end else if (w_do_rot) begin
                if (LEN_W'(c) == w_count7 - LEN_W'(1)) begin
                    w_sel[c] = SEL_LOAD;
                end else begin
                    w_sel[c] = SEL_RIGHT;
                end
            end
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cells
        logic [HANDLE_BITS-1:0] w_left;
        logic [HANDLE_BITS-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_cell[g];
        end else begin : g_inner_l
            assign w_left = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_cell[g];
        end else begin : g_inner_r
            assign w_right = w_cell[g+1];
        end

        ple_cell #(
            .WIDTH (HANDLE_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_sel   (w_sel[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_new   (w_new),
            .o_data  (w_cell[g])
        );
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_ovalid   = r_ovalid && !o_out.ready;
        n_o_handle = r_o_handle;
        n_o_status = r_o_status;
        n_o_hvalid = r_o_hvalid;
        n_o_last   = r_o_last;

        if (w_acc) begin
            if (w_is_ins) begin
                n_ovalid   = 1'b1;
                n_o_handle = '0;
                n_o_status = w_ins_st;
                n_o_hvalid = 1'b0;
                n_o_last   = 1'b1;
                if (w_do_ins) begin
                    n_count = r_count + CNT_W'(1);
                end
            end else if (w_is_rem) begin
                n_ovalid   = 1'b1;
                n_o_handle = w_do_rem ? HANDLE_W'(w_cell[w_rem_tgt[IDX_W-1:0]]) : '0;
                n_o_status = w_rem_st;
                n_o_hvalid = w_do_rem;
                n_o_last   = 1'b1;
                if (w_do_rem) begin
                    n_count = r_count - CNT_W'(1);
                end
            end else if (i_in.action == ACT_DUMP) begin
                if (w_empty) begin
                    n_ovalid   = 1'b1;
                    n_o_handle = '0;
                    n_o_status = STAT_EMPTY;
                    n_o_hvalid = 1'b0;
                    n_o_last   = 1'b1;
                end else begin
                    n_state = S_DUMP;
                    n_idx   = '0;
                end
            end
        end

        if (w_do_rot) begin
            n_ovalid   = 1'b1;
            n_o_handle = HANDLE_W'(w_cell[0]);
            n_o_status = STAT_OK;
            n_o_hvalid = 1'b1;
            n_o_last   = w_dump_last;
            n_idx      = r_idx + CNT_W'(1);
            if (w_dump_last) begin
                n_state = S_IDLE;
            end
        end

        // The count only moves together with a new result, so this is always right.
        n_o_len = LEN_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_handle <= n_o_handle;
        r_o_status <= n_o_status;
        r_o_hvalid <= n_o_hvalid;
        r_o_last   <= n_o_last;
        r_o_len    <= n_o_len;
    end

    assign o_out.valid        = r_ovalid;
    assign o_out.out_handle   = r_o_handle;
    assign o_out.status       = r_o_status;
    assign o_out.handle_valid = r_o_hvalid;
    assign o_out.last         = r_o_last;
    assign o_out.length_after = r_o_len;

    `PLE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, w_count7 <= LEN_W'(CAPACITY))
    `PLE_ASSERT_NOW(a_dump_idx, i_clk, i_rst_n, r_state == S_DUMP, r_idx < r_count)
    `PLE_ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, w_acc && w_is_ins && w_full,
                     $stable(r_count) && r_ovalid && (r_o_status == STAT_FULL))
    `PLE_ASSERT_NEXT(a_rem_valid, i_clk, i_rst_n, w_do_rem,
                     r_ovalid && r_o_hvalid && (r_o_len == w_count7))

endmodule

[bench/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ple_pkg::*;

    localparam int          CAPACITY     = 64;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          SETTLE_LEN   = 20;
    localparam int          IDLE_PCT     = 26;
    localparam int          HOLD_LEN     = 150;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
        logic                hvalid;
        logic                last;
        logic [LEN_W-1:0]    length;
    } list_result_t;

    typedef struct packed {
        logic [ACT_W-1:0]    act;
        logic [POS_W-1:0]    pos;
        logic [HANDLE_W-1:0] hdl;
        logic                typed;
        list_result_t        want;
    } list_cmd_t;

    logic i_clk;
    logic i_rst_n;

    ple_in_if  in_if();
    ple_out_if out_if();

    positional_list_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    logic [HANDLE_W-1:0] list_model[$];
    list_result_t        expected_results[$];
    list_result_t        head_want;
    list_cmd_t           directed_rows[$];
    int unsigned         mismatch_count;
    int unsigned         cycle_count;
    int                  hold_left;
    bit                  steady;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Walks the list model through one command and queues the results it causes.
    function automatic void predict_list(input list_cmd_t c);
        list_result_t res[$];
        list_result_t r;
        int           at;
        int           len;

        len = list_model.size();
        r = '0;
        r.last = 1'b1;
        case (c.act)
            ACT_INS_HEAD, ACT_INS_TAIL, ACT_INS_POS: begin
                at = (c.act == ACT_INS_HEAD) ? 0 : (c.act == ACT_INS_TAIL) ? len : int'(c.pos);
                if (len >= CAPACITY) begin
                    r.status = STAT_FULL;
                end else if (at > len) begin
                    r.status = STAT_RANGE;
                end else begin
                    list_model.insert(at, c.hdl);
                    r.status = STAT_OK;
                end
                r.length = LEN_W'(list_model.size());
                res.push_back(r);
            end
            ACT_REM_HEAD, ACT_REM_TAIL, ACT_REM_POS: begin
                at = (c.act == ACT_REM_HEAD) ? 0 :
                     (c.act == ACT_REM_TAIL) ? ((len == 0) ? 0 : len - 1) : int'(c.pos);
                if (len == 0) begin
                    r.status = STAT_EMPTY;
                end else if (at >= len) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.handle = list_model[at];
                    r.hvalid = 1'b1;
                    r.status = STAT_OK;
                    list_model.delete(at);
                end
                r.length = LEN_W'(list_model.size());
                res.push_back(r);
            end
            ACT_DUMP: begin
                if (len == 0) begin
                    r.status = STAT_EMPTY;
                    res.push_back(r);
                end else begin
                    foreach (list_model[i]) begin
                        r.handle = list_model[i];
                        r.status = STAT_OK;
                        r.hvalid = 1'b1;
                        r.last   = (i == len - 1);
                        r.length = LEN_W'(len);
                        res.push_back(r);
                    end
                end
            end
            default: ;
        endcase
        if (c.typed)
            expected_results.push_back(c.want);
        else
            foreach (res[i]) expected_results.push_back(res[i]);
    endfunction

    function automatic list_cmd_t cmd_row(input logic [ACT_W-1:0] act, input int unsigned pos,
                                          input int unsigned hdl);
        list_cmd_t c;
        c = '0;
        c.act = act;
        c.pos = POS_W'(pos);
        c.hdl = HANDLE_W'(hdl);
        return c;
    endfunction

    // A row whose single result is written out by hand; last is always set.
    function automatic list_cmd_t cmd_row_exp(input logic [ACT_W-1:0] act,
                                              input int unsigned pos, input int unsigned hdl,
                                              input int unsigned handle,
                                              input logic [STATUS_W-1:0] status,
                                              input bit hvalid, input int unsigned length);
        list_cmd_t c;
        c = cmd_row(act, pos, hdl);
        c.typed       = 1'b1;
        c.want.handle = HANDLE_W'(handle);
        c.want.status = status;
        c.want.hvalid = hvalid;
        c.want.last   = 1'b1;
        c.want.length = LEN_W'(length);
        return c;
    endfunction

    function automatic list_cmd_t random_cmd(input int unsigned ins_pct);
        list_cmd_t   c;
        int unsigned pick;
        int unsigned len;

        c = '0;
        len = list_model.size();
        c.hdl = HANDLE_W'($urandom_range(2047));
        pick = $urandom_range(99);
        if (pick < ins_pct) begin
            case ($urandom_range(2))
                0:       c.act = ACT_INS_HEAD;
                1:       c.act = ACT_INS_TAIL;
                default: c.act = ACT_INS_POS;
            endcase
            c.pos = POS_W'((len > 63) ? 63 : $urandom_range(len));
        end else if (pick < 90) begin
            case ($urandom_range(2))
                0:       c.act = ACT_REM_HEAD;
                1:       c.act = ACT_REM_TAIL;
                default: c.act = ACT_REM_POS;
            endcase
            c.pos = POS_W'((len == 0) ? $urandom_range(63) : $urandom_range(len - 1));
        end else if (pick < 97) begin
            c.act = ACT_DUMP;
            c.pos = POS_W'($urandom_range(63));
        end else begin
            c.act = ACT_UNUSED;
            c.pos = POS_W'($urandom_range(63));
        end
        // Some positions land anywhere in the full position range.
        if ($urandom_range(99) < 20)
            c.pos = POS_W'($urandom_range(63));
        return c;
    endfunction

    // Entered and left at a falling edge; valid stays high between back-to-back transfers.
    task automatic send_cmd(input list_cmd_t c);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid         <= 1'b1;
        in_if.action        <= c.act;
        in_if.position      <= c.pos;
        in_if.record_handle <= c.hdl;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_list(c);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
    endtask

    // Receiver side: random stalls, a stall-free stretch, and one long hold-off.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result, handle", 32'(out_if.out_handle), 0);
            end else begin
                head_want = expected_results.pop_front();
                if (out_if.out_handle !== head_want.handle)
                    report_mismatch("out_handle", 32'(out_if.out_handle),
                                    32'(head_want.handle));
                if (out_if.status !== head_want.status)
                    report_mismatch("status", 32'(out_if.status), 32'(head_want.status));
                if (out_if.handle_valid !== head_want.hvalid)
                    report_mismatch("handle_valid", 32'(out_if.handle_valid),
                                    32'(head_want.hvalid));
                if (out_if.last !== head_want.last)
                    report_mismatch("last", 32'(out_if.last), 32'(head_want.last));
                if (out_if.length_after !== head_want.length)
                    report_mismatch("length_after", 32'(out_if.length_after),
                                    32'(head_want.length));
            end
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        in_if.valid         = 1'b0;
        in_if.action        = '0;
        in_if.position      = '0;
        in_if.record_handle = '0;
        mismatch_count      = 0;
        cycle_count         = 0;
        hold_left           = 0;
        steady              = 1'b0;

        //                          action        pos  handle  out   status      hv len
        directed_rows.push_back(cmd_row_exp(ACT_REM_HEAD, 0,  0,     0, STAT_EMPTY, 0, 0));
        directed_rows.push_back(cmd_row_exp(ACT_REM_TAIL, 0,  0,     0, STAT_EMPTY, 0, 0));
        directed_rows.push_back(cmd_row_exp(ACT_REM_POS,  63, 2047,  0, STAT_EMPTY, 0, 0));
        directed_rows.push_back(cmd_row_exp(ACT_DUMP,     0,  0,     0, STAT_EMPTY, 0, 0));
        directed_rows.push_back(cmd_row_exp(ACT_INS_POS,  1,  5,     0, STAT_RANGE, 0, 0));
        directed_rows.push_back(cmd_row_exp(ACT_INS_POS,  0,  2047,  0, STAT_OK,    0, 1));
        directed_rows.push_back(cmd_row_exp(ACT_INS_HEAD, 0,  0,     0, STAT_OK,    0, 2));
        directed_rows.push_back(cmd_row_exp(ACT_INS_TAIL, 0,  'h555, 0, STAT_OK,    0, 3));
        directed_rows.push_back(cmd_row_exp(ACT_INS_POS,  3,  'h2aa, 0, STAT_OK,    0, 4));
        directed_rows.push_back(cmd_row_exp(ACT_INS_POS,  63, 2047,  0, STAT_RANGE, 0, 4));
        directed_rows.push_back(cmd_row(ACT_INS_POS,  1,  'h123));
        directed_rows.push_back(cmd_row(ACT_UNUSED,   63, 2047));
        directed_rows.push_back(cmd_row(ACT_DUMP,     0,  0));
        directed_rows.push_back(cmd_row_exp(ACT_REM_POS,  5,  0,     0, STAT_RANGE, 0, 5));
        directed_rows.push_back(cmd_row_exp(ACT_REM_POS,  63, 0,     0, STAT_RANGE, 0, 5));
        directed_rows.push_back(cmd_row(ACT_REM_HEAD, 0,  0));
        directed_rows.push_back(cmd_row(ACT_REM_POS,  2,  0));
        directed_rows.push_back(cmd_row(ACT_REM_TAIL, 0,  0));
        directed_rows.push_back(cmd_row(ACT_DUMP,     0,  0));
        directed_rows.push_back(cmd_row(ACT_INS_HEAD, 0,  'h400));
        directed_rows.push_back(cmd_row(ACT_REM_POS,  0,  0));
        directed_rows.push_back(cmd_row(ACT_REM_TAIL, 0,  0));
        directed_rows.push_back(cmd_row(ACT_REM_TAIL, 0,  0));
        directed_rows.push_back(cmd_row_exp(ACT_REM_TAIL, 0,  0,     0, STAT_EMPTY, 0, 0));

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) send_cmd(directed_rows[i]);

        // Random mix that leans toward growing the list.
        repeat (20) send_cmd(random_cmd(85));

        // Pause until the block has nothing left to deliver, then fill the list with
        // no idling while the receiver holds off, so the input backs up.
        wait_drained();
        steady = 1'b1;
        hold_left = HOLD_LEN;
        while (list_model.size() < CAPACITY - 1) begin
            if ($urandom_range(3) == 0)
                send_cmd(cmd_row(ACT_INS_HEAD, 0, $urandom_range(2047)));
            else
                send_cmd(cmd_row(ACT_INS_TAIL, 0, $urandom_range(2047)));
        end
        send_cmd(cmd_row(ACT_INS_POS, 63, $urandom_range(2047)));
        send_cmd(cmd_row(ACT_INS_HEAD, 0, $urandom_range(2047)));
        send_cmd(cmd_row(ACT_INS_TAIL, 0, $urandom_range(2047)));
        send_cmd(cmd_row(ACT_INS_POS, $urandom_range(63), $urandom_range(2047)));
        send_cmd(cmd_row(ACT_DUMP, 0, 0));
        send_cmd(cmd_row(ACT_REM_POS, 63, 0));
        send_cmd(cmd_row(ACT_INS_POS, 62, $urandom_range(2047)));
        repeat (8) send_cmd(random_cmd(40));
        steady = 1'b0;

        // Random mix that leans toward draining the list.
        repeat (10) send_cmd(random_cmd(30));

        wait_drained();
        repeat (SETTLE_LEN) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/ple_pkg.sv
design/ple_in_if.sv
design/ple_out_if.sv
design/ple_cell.sv
design/positional_list_engine.sv
bench/tb_top.sv
